FILE: rtl/a85_pkg.sv
package a85_pkg;

    localparam int A85_DIGITS = 5;
    localparam int A85_IDX_W = $clog2(A85_DIGITS);
    localparam int A85_QDEPTH = 2;
    localparam int A85_QPTR_W = (A85_QDEPTH > 1) ? $clog2(A85_QDEPTH) : 1;
    localparam int A85_QCNT_W = $clog2(A85_QDEPTH + 1);

    localparam logic [6:0] A85_RADIX = 7'd85;
    localparam logic [6:0] A85_OFFSET = 7'd33;
    localparam logic [6:0] A85_ZERO_CHAR = 7'h7A;

    // Exact quotient by 85 for any 32-bit value: q = (w * A85_RECIP) >> A85_SHIFT.
    localparam logic [31:0] A85_RECIP = 32'hC0C0_C0C1;
    localparam int A85_SHIFT = 38;
    localparam int A85_QUO_W = 26;

    typedef struct packed {
        logic [31:0] word;
        logic fin;
    } a85_qent_t;

    typedef struct packed {
        logic zero;
        logic fin;
        logic [A85_DIGITS-1:0][6:0] digits;
    } a85_group_t;

endpackage

FILE: rtl/ascii85_stream_encoder.sv
// Channel   Direction  Ports                                       Transfer when
// s_        in         s_data_byte, s_final_byte                   s_valid && s_ready
// m_        out        m_out_char, m_group_end, m_stream_end       m_valid && m_ready
//
// A byte is taken in every cycle while the two-entry group queue has room.
// A nonzero group is loaded into the divider, which then writes one base-85 digit
// per cycle via a single 32x32 reciprocal multiplier; a zero group skips the digits.
// The emitter's output register sends up to five characters, one per ready cycle.
// Synchronous active-low reset empties the queue and clears the partial group.
// Each side stalls on its own: m_ready low only backs up the queue and then s_ready.
module ascii85_stream_encoder import a85_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_out_char,
    output logic       m_group_end,
    output logic       m_stream_end
);

    logic       push_valid;
    logic       push_ready;
    a85_qent_t  push_data;
    logic       q_valid;
    logic       q_ready;
    a85_qent_t  q_data;
    logic       g_valid;
    logic       g_ready;
    a85_group_t g_data;

    a85_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    a85_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    a85_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .g_valid (g_valid),
        .g_ready (g_ready),
        .g_data  (g_data)
    );

    a85_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .g_valid      (g_valid),
        .g_ready      (g_ready),
        .g_data       (g_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_group_end  (m_group_end),
        .m_stream_end (m_stream_end)
    );

endmodule

FILE: rtl/a85_front.sv
module a85_front import a85_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    output logic       push_valid,
    input  logic       push_ready,
    output a85_qent_t  push_data
);

    logic [23:0] group_word_reg, group_word_next;
    logic [1:0]  bytes_held_reg, bytes_held_next;
    logic        take;
    logic        close;
    logic [31:0] padded;

    assign s_ready = push_ready;
    assign take = s_valid && s_ready;
    assign close = (bytes_held_reg == 2'd3) || s_final_byte;

    always_comb begin
        case (bytes_held_reg)
            2'd0: padded = {s_data_byte, 24'd0};
            2'd1: padded = {group_word_reg[7:0], s_data_byte, 16'd0};
            2'd2: padded = {group_word_reg[15:0], s_data_byte, 8'd0};
            default: padded = {group_word_reg, s_data_byte};
        endcase
    end

    assign push_valid = take && close;
    assign push_data.word = padded;
    assign push_data.fin = s_final_byte;

    always_comb begin
        group_word_next = group_word_reg;
        bytes_held_next = bytes_held_reg;
        if (take) begin
            if (close) begin
                group_word_next = 24'd0;
                bytes_held_next = 2'd0;
            end else begin
                group_word_next = {group_word_reg[15:0], s_data_byte};
                bytes_held_next = bytes_held_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_word_reg <= 24'd0;
            bytes_held_reg <= 2'd0;
        end else begin
            group_word_reg <= group_word_next;
            bytes_held_reg <= bytes_held_next;
        end
    end

endmodule

FILE: rtl/a85_queue.sv
module a85_queue import a85_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  a85_qent_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output a85_qent_t rd_data
);

    a85_qent_t               mem_reg [A85_QDEPTH];
    logic [A85_QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [A85_QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [A85_QCNT_W-1:0]   count_reg, count_next;
    logic                    do_wr;
    logic                    do_rd;

    assign wr_ready = (count_reg != A85_QCNT_W'(A85_QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == A85_QPTR_W'(A85_QDEPTH - 1)) ? '0
                        : wr_ptr_reg + A85_QPTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == A85_QPTR_W'(A85_QDEPTH - 1)) ? '0
                        : rd_ptr_reg + A85_QPTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + A85_QCNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - A85_QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/a85_divider.sv
module a85_divider import a85_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  a85_qent_t  q_data,
    output logic       g_valid,
    input  logic       g_ready,
    output a85_group_t g_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [31:0]                w_reg, w_next;
    logic [63:0]                p_reg, p_next;
    logic [A85_IDX_W-1:0]       cnt_reg, cnt_next;
    a85_group_t                 group_reg, group_next;
    logic                       load;
    logic [A85_QUO_W-1:0]       quo;
    logic [6:0]                 rem;
    logic [31:0]                mul_a;
    logic [A85_IDX_W-1:0]       slot;

    assign quo = p_reg[A85_SHIFT +: A85_QUO_W];
    assign rem = w_reg[6:0] - 7'(quo[6:0] * A85_RADIX);
    assign slot = A85_IDX_W'(A85_DIGITS - 1) - cnt_reg;

    assign q_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && g_ready);
    assign load = q_valid && q_ready;
    assign g_valid = (state_reg == ST_DONE);
    assign g_data = group_reg;

    assign mul_a = (state_reg == ST_BUSY) ? 32'(quo) : q_data.word;
    assign p_next = 64'(mul_a) * 64'(A85_RECIP);

    always_comb begin
        state_next = state_reg;
        w_next = w_reg;
        cnt_next = cnt_reg;
        group_next = group_reg;
        case (state_reg)
            ST_BUSY: begin
                group_next.digits[slot] = rem;
                w_next = 32'(quo);
                cnt_next = cnt_reg + A85_IDX_W'(1);
                if (cnt_reg == A85_IDX_W'(A85_DIGITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (g_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
            end
        endcase
        if (load) begin
            w_next = q_data.word;
            cnt_next = '0;
            group_next.zero = (q_data.word == 32'd0);
            group_next.fin = q_data.fin;
            state_next = (q_data.word == 32'd0) ? ST_DONE : ST_BUSY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
        p_reg <= p_next;
        group_reg <= group_next;
    end

endmodule

FILE: rtl/a85_emitter.sv
module a85_emitter import a85_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       g_valid,
    output logic       g_ready,
    input  a85_group_t g_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_out_char,
    output logic       m_group_end,
    output logic       m_stream_end
);

    a85_group_t            group_reg, group_next;
    logic                  busy_reg, busy_next;
    logic [A85_IDX_W-1:0]  idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic [6:0]            char_reg, char_next;
    logic                  gend_reg, gend_next;
    logic                  send_reg, send_next;
    logic                  issue;
    logic                  last;

    assign issue = busy_reg && (!valid_reg || m_ready);
    assign last = group_reg.zero || (idx_reg == A85_IDX_W'(A85_DIGITS - 1));
    assign g_ready = !busy_reg || (issue && last);

    assign m_valid = valid_reg;
    assign m_out_char = char_reg;
    assign m_group_end = gend_reg;
    assign m_stream_end = send_reg;

    always_comb begin
        group_next = group_reg;
        busy_next = busy_reg;
        idx_next = idx_reg;
        valid_next = valid_reg && !m_ready;
        char_next = char_reg;
        gend_next = gend_reg;
        send_next = send_reg;
        if (issue) begin
            valid_next = 1'b1;
            char_next = group_reg.zero ? A85_ZERO_CHAR
                      : 7'(group_reg.digits[idx_reg] + A85_OFFSET);
            gend_next = last;
            send_next = last && group_reg.fin;
            idx_next = idx_reg + A85_IDX_W'(1);
            if (last) begin
                busy_next = 1'b0;
            end
        end
        if (g_valid && g_ready) begin
            group_next = g_data;
            busy_next = 1'b1;
            idx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            idx_reg <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        group_reg <= group_next;
        char_reg <= char_next;
        gend_reg <= gend_next;
        send_reg <= send_next;
    end

    a_zero_char_ends_group: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (char_reg == A85_ZERO_CHAR) |-> gend_reg)
        else $error("zero-group character without group end");

    a_group_take_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        g_valid && g_ready |=> busy_reg && (idx_reg == '0))
        else $error("group taken but emission did not start");

    a_zero_group_single: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && group_reg.zero |-> (idx_reg == '0))
        else $error("zero group emitted more than one character");

    a_stream_end_on_group_end: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && send_reg |-> gend_reg)
        else $error("stream end flagged inside a group");

endmodule

FILE: sim/testbench.sv
module testbench;
    import a85_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 310;
    localparam int LONG_HOLD = 400;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [7:0] data;
        logic       fin;
        int         gap;
        logic       drain;
    } src_item_t;

    typedef struct {
        logic [6:0] ch;
        logic       gend;
        logic       send;
    } a85_char_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_final_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [6:0] m_out_char;
    logic       m_group_end;
    logic       m_stream_end;

    src_item_t source_q[$];
    a85_char_t char_q[$];

    // Encoder state as seen by the predictor.
    logic [23:0] held_word = '0;
    logic [1:0]  held_cnt = '0;

    int n_bytes = 0;
    int n_chars = 0;
    int n_zero_groups = 0;
    int n_short_groups = 0;
    int n_streams = 0;
    int n_errors = 0;
    int idle_cycles = 0;

    ascii85_stream_encoder u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_final_byte(s_final_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_group_end (m_group_end),
        .m_stream_end(m_stream_end)
    );

    always #2 aclk = ~aclk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at char %0d: %s got %0d, expected %0d", n_chars, what, got, want);
        n_errors++;
    endtask

    task automatic push_char(input logic [6:0] ch, input logic gend, input logic send);
        a85_char_t c;
        c.ch = ch;
        c.gend = gend;
        c.send = send;
        char_q.push_back(c);
    endtask

    // Gathers one byte and, when a group closes, queues the characters it encodes to.
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [31:0] word;
        logic [6:0]  digit[5];
        int          i;
        if (held_cnt < 2'd3 && !fin) begin
            held_word = {held_word[15:0], b};
            held_cnt = held_cnt + 2'd1;
        end else begin
            word = {held_word, b} << (8 * (3 - int'(held_cnt)));
            if (fin) begin
                n_streams++;
                if (held_cnt < 2'd3) begin
                    n_short_groups++;
                end
            end
            held_word = '0;
            held_cnt = '0;
            if (word == 32'd0) begin
                n_zero_groups++;
                push_char(A85_ZERO_CHAR, 1'b1, fin);
            end else begin
                for (i = 4; i >= 0; i--) begin
                    digit[i] = 7'(word % 32'(A85_RADIX));
                    word = word / 32'(A85_RADIX);
                end
                for (i = 0; i < 5; i++) begin
                    push_char(digit[i] + A85_OFFSET, i == 4, (i == 4) && fin);
                end
            end
        end
    endtask

    task automatic add_item(input logic [7:0] data, input logic fin, input int gap,
                            input logic drain);
        src_item_t it;
        it.data = data;
        it.fin = fin;
        it.gap = gap;
        it.drain = drain;
        source_q.push_back(it);
    endtask

    // Source side: offers queued bytes, honoring per-item gaps and drain requests.
    always @(posedge aclk) begin
        int        gap_left;
        logic      busy;
        logic      nxt_valid;
        src_item_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                encode_byte(s_data_byte, s_final_byte);
                n_bytes++;
                busy = 1'b0;
            end
            if (!busy) begin
                nxt_valid = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (source_q.size() != 0) begin
                    if (source_q[0].gap != 0) begin
                        gap_left = source_q[0].gap - 1;
                        source_q[0].gap = 0;
                    end else if (!(source_q[0].drain && char_q.size() != 0)) begin
                        cur = source_q.pop_front();
                        s_data_byte <= cur.data;
                        s_final_byte <= cur.fin;
                        nxt_valid = 1'b1;
                    end
                end
                s_valid <= nxt_valid;
            end
        end
    end

    // Sink side: checks each transfer against the oldest predicted character.
    always @(posedge aclk) begin
        int        hold_left;
        int        window;
        logic      steady;
        logic      nxt_ready;
        a85_char_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
            window = 0;
            steady = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (char_q.size() == 0) begin
                    report_mismatch("out_char with none pending", m_out_char, -1);
                end else begin
                    want = char_q.pop_front();
                    if (m_out_char !== want.ch) begin
                        report_mismatch("out_char", m_out_char, want.ch);
                    end
                    if (m_group_end !== want.gend) begin
                        report_mismatch("group_end", m_group_end, want.gend);
                    end
                    if (m_stream_end !== want.send) begin
                        report_mismatch("stream_end", m_stream_end, want.send);
                    end
                end
                n_chars++;
                if (n_chars == 40 || n_chars == 300) begin
                    hold_left = LONG_HOLD;
                end
            end
            if (window == 0) begin
                window = 50;
                steady = ($urandom_range(0, 3) == 0);
            end
            window--;
            if (hold_left != 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else if (steady || $urandom_range(0, 99) < 70) begin
                nxt_ready = 1'b1;
            end else begin
                nxt_ready = 1'b0;
                hold_left = idle_len();
            end
            m_ready <= nxt_ready;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int   i;
        int   run_gap;
        logic burst;
        logic [7:0] b;

        // Zero group, all-ones group, then short final groups of one to three bytes.
        for (i = 0; i < 4; i++) add_item(8'h00, 1'b0, 0, 1'b0);
        for (i = 0; i < 4; i++) add_item(8'hFF, 1'b0, 0, 1'b0);
        add_item(8'h00, 1'b1, 0, 1'b0);
        add_item(8'hFF, 1'b1, 0, 1'b0);
        add_item(8'h12, 1'b0, 0, 1'b0);
        add_item(8'h34, 1'b1, 0, 1'b0);
        add_item(8'h80, 1'b0, 0, 1'b0);
        add_item(8'h00, 1'b0, 0, 1'b0);
        add_item(8'h01, 1'b1, 0, 1'b0);
        // Full groups closed by the final mark: one zero, one nonzero.
        for (i = 0; i < 4; i++) add_item(8'h00, i == 3, 0, 1'b0);
        for (i = 0; i < 4; i++) add_item(8'(i + 1), i == 3, 0, 1'b0);

        burst = 1'b0;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 16 == 0) begin
                burst = ($urandom_range(0, 2) == 0);
            end
            b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            run_gap = burst ? 0 : idle_len();
            add_item(b, (i == RANDOM_ITEMS - 1) || ($urandom_range(0, 5) == 0), run_gap,
                     i == 0 || i == 120 || i == 240);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (source_q.size() != 0 || s_valid) @(posedge aclk);
        while (char_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d bytes in %0d streams, %0d characters checked", n_bytes,
                 n_streams, n_chars);
        $display("zero groups %0d, short final groups %0d, mismatches %0d", n_zero_groups,
                 n_short_groups, n_errors);
        if (n_errors == 0 && char_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/a85_pkg.sv
rtl/a85_front.sv
rtl/a85_queue.sv
rtl/a85_divider.sv
rtl/a85_emitter.sv
rtl/ascii85_stream_encoder.sv
sim/testbench.sv
